// ----- design/mplm_pkg.sv -----
// package for the multi-pll lock monitor: sizes, codes, request/result structs, abs and saturating add helpers
// no dependencies
`default_nettype none
package mplm_pkg;
	localparam int MAX_NODES = 16;
	localparam int SLOT_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);

	localparam logic [1:0] FUNC_PHASE = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_ASSIGN = 2'd2;
	localparam logic [1:0] FUNC_QUERY = 2'd3;

	localparam logic [1:0] REG_TOL = 2'd0;
	localparam logic [1:0] REG_SETTLE = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [15:0] anchor;
		logic [3:0] slot;
		logic signed [15:0] phase_error;
		logic [31:0] timestamp;
	} req_t;

	typedef struct packed {
		logic network_locked;
		logic anchor_found;
		logic slot_locked;
		logic signed [15:0] slot_phase_error;
		logic [14:0] slot_peak_error;
		logic [31:0] slot_lock_time;
		logic [31:0] slot_settling_time;
	} res_t;

	function automatic logic [15:0] abs16(input logic signed [15:0] e);
		return e[15] ? 16'(-e) : 16'(e);
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction
endpackage
`default_nettype wire

// ----- design/multi_pll_lock_monitor.sv -----
// multi-pll lock monitor top level: slot table, sequencer walking one slot per cycle
// depends on mplm_pkg
//
// channel  dir  handshake          payload
// request  in   start / busy       req (req_t)
// result   out  done strobe        res (res_t)
// config   in   cfg_valid/ready    cfg_index, cfg_data
//
// phase reports and ticks walk the used slots one per cycle (one shared slot unit),
// then every request walks them again for the network lock flag; an assign or
// query skips the first walk. busy drops in the cycle the strobe is high, and a
// new request can be accepted in that cycle.
// reset clears the whole table at once (flip-flops). results cannot be stalled.
`default_nettype none
module multi_pll_lock_monitor (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire mplm_pkg::req_t req,
	output logic done,
	output mplm_pkg::res_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	import mplm_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_WALK, S_LOCK, S_DONE} state_t;

	state_t state_q;
	req_t req_q;
	logic [CNT_W-1:0] idx_q;
	logic found_q, net_q;
	logic [14:0] tol_q;
	logic [31:0] limit_q;
	logic [4:0] count_q;
	logic [15:0] anchor_q [MAX_NODES];
	logic signed [15:0] err_q [MAX_NODES];
	logic [14:0] peak_q [MAX_NODES];
	logic [31:0] ltim_q [MAX_NODES];
	logic [31:0] stim_q [MAX_NODES];
	logic lflag_q [MAX_NODES];
	logic [31:0] prev_q;
	logic first_q;
	logic dt_ok_q;
	logic [31:0] dt_q;

	logic [CNT_W-1:0] used;
	logic [SLOT_W-1:0] si;
	logic [15:0] a_in, a_cur;
	logic [14:0] a_sat;

	assign used = (count_q > 5'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(count_q);
	assign si = idx_q[SLOT_W-1:0];
	assign a_in = abs16(req_q.phase_error);
	assign a_sat = a_in[15] ? 15'h7FFF : a_in[14:0];
	assign a_cur = abs16(err_q[si]);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			found_q <= 1'b0;
			net_q <= 1'b0;
			done <= 1'b0;
			res <= '0;
			tol_q <= 15'd100;
			limit_q <= 32'd1000000;
			count_q <= '0;
			prev_q <= '0;
			first_q <= 1'b1;
			dt_ok_q <= 1'b0;
			dt_q <= '0;
			req_q <= '0;
			for (int i = 0; i < MAX_NODES; i++) begin
				anchor_q[i] <= '0;
				err_q[i] <= '0;
				peak_q[i] <= '0;
				ltim_q[i] <= '0;
				stim_q[i] <= '0;
				lflag_q[i] <= 1'b0;
			end
		end else begin
			done <= (state_q == S_DONE);
			if (cfg_valid) begin
				case (cfg_index)
					REG_TOL: tol_q <= cfg_data[14:0];
					REG_SETTLE: limit_q <= cfg_data;
					REG_COUNT: count_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						idx_q <= '0;
						found_q <= 1'b0;
						net_q <= 1'b1;
						state_q <= S_WALK;
						dt_q <= req.timestamp - prev_q;
						dt_ok_q <= (req.func == FUNC_TICK) && !first_q
							&& (req.timestamp > prev_q);
						if (req.func == FUNC_TICK) begin
							prev_q <= req.timestamp;
							first_q <= 1'b0;
						end
						if (req.func == FUNC_ASSIGN
							&& anchor_q[req.slot[SLOT_W-1:0]] != req.anchor) begin
							anchor_q[req.slot[SLOT_W-1:0]] <= req.anchor;
							err_q[req.slot[SLOT_W-1:0]] <= '0;
							peak_q[req.slot[SLOT_W-1:0]] <= '0;
							ltim_q[req.slot[SLOT_W-1:0]] <= '0;
							stim_q[req.slot[SLOT_W-1:0]] <= '0;
							lflag_q[req.slot[SLOT_W-1:0]] <= 1'b0;
						end
					end
				end
				S_WALK: begin
					// one slot per cycle through the shared update unit
					if (idx_q >= used || req_q.func == FUNC_ASSIGN
						|| req_q.func == FUNC_QUERY) begin
						idx_q <= '0;
						state_q <= S_LOCK;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (req_q.func == FUNC_PHASE && !found_q
							&& anchor_q[si] == req_q.anchor) begin
							found_q <= 1'b1;
							err_q[si] <= req_q.phase_error;
							if (a_sat > peak_q[si]) peak_q[si] <= a_sat;
						end
						if (req_q.func == FUNC_TICK && dt_ok_q) begin
							if (a_cur <= {1'b0, tol_q}) begin
								if (!lflag_q[si]) begin
									stim_q[si] <= sat_add(stim_q[si], dt_q);
									lflag_q[si] <= 1'b1;
								end else begin
									ltim_q[si] <= sat_add(ltim_q[si], dt_q);
								end
							end else begin
								lflag_q[si] <= 1'b0;
								ltim_q[si] <= '0;
								stim_q[si] <= sat_add(stim_q[si], dt_q);
							end
						end
					end
				end
				S_LOCK: begin
					if (idx_q >= used) begin
						if (used == '0) net_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (!lflag_q[si] || a_cur > {1'b0, tol_q} || stim_q[si] > limit_q)
							net_q <= 1'b0;
					end
				end
				S_DONE: begin
					res.network_locked <= net_q;
					res.anchor_found <= found_q;
					if (req_q.func == FUNC_QUERY) begin
						res.slot_locked <= lflag_q[req_q.slot[SLOT_W-1:0]];
						res.slot_phase_error <= err_q[req_q.slot[SLOT_W-1:0]];
						res.slot_peak_error <= peak_q[req_q.slot[SLOT_W-1:0]];
						res.slot_lock_time <= ltim_q[req_q.slot[SLOT_W-1:0]];
						res.slot_settling_time <= stim_q[req_q.slot[SLOT_W-1:0]];
					end else begin
						res.slot_locked <= 1'b0;
						res.slot_phase_error <= '0;
						res.slot_peak_error <= '0;
						res.slot_lock_time <= '0;
						res.slot_settling_time <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_found_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.anchor_found |-> $past(req_q.func) == FUNC_PHASE)
		else $error("anchor_found on non-report");
	a_net_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.network_locked |-> $past(used) != '0)
		else $error("network lock with no nodes");
endmodule
`default_nettype wire
